>>> hw/rtl/b64dec_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base64 decoder package
// Shared types, constants and the alphabet lookup of the Base64 decoder.
// ----------------------------------------------------------------------------
package b64dec_pkg;

    // Character codes with a meaning of their own.
    localparam logic [7:0] PAD_CHAR = 8'h3D;

    // Output buffer geometry.
    localparam int          FIFO_DEPTH = 8;
    localparam int          PTR_W      = $clog2(FIFO_DEPTH);
    localparam int          CNT_W      = $clog2(FIFO_DEPTH + 1);
    // The most bytes one item can cause.
    localparam int          MAX_PUSH   = 3;
    // Highest buffer fill, after the held item's bytes, that still admits an item.
    localparam int          READY_LIMIT = FIFO_DEPTH - MAX_PUSH;

    // One decoded character: valid flag and its 6-bit value.
    typedef struct packed {
        logic       vld;
        logic [5:0] val;
    } t_sextet;

    // One buffered result item.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_entry;

    // Map a raw byte through the standard alphabet (A-Z a-z 0-9 + /).
    function automatic t_sextet sextet_of(input logic [7:0] c);
        t_sextet r;
        r.vld = 1'b1;
        r.val = 6'd0;
        if (c >= 8'h41 && c <= 8'h5A) begin
            r.val = 6'(c - 8'h41);
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            r.val = 6'(c - 8'h61 + 8'd26);
        end else if (c >= 8'h30 && c <= 8'h39) begin
            r.val = 6'(c - 8'h30 + 8'd52);
        end else if (c == 8'h2B) begin
            r.val = 6'd62;
        end else if (c == 8'h2F) begin
            r.val = 6'd63;
        end else begin
            r.vld = 1'b0;
        end
        return r;
    endfunction

endpackage

>>> hw/rtl/base64_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base64 decoder
// Streaming decoder: one character per item in, decoded bytes out.
// ----------------------------------------------------------------------------
//  Channel   Direction  Payload
//  s_axis    in         tdata = in_char[7:0], tlast = end_of_input
//  m_axis    out        tdata = out_byte[7:0], tlast = run_last
//
//  One character is taken per cycle while s_axis_tready is high. Its bytes
//  are written to the 8-entry output buffer at the edge after acceptance;
//  they then leave one per cycle while m_axis_tready is high.
//  s_axis_tready falls only while the buffer could not take three more bytes
//  (the most one item causes); a stalled m_axis side fills it.
//  i_rst_n is synchronous, active low, and clears the group and the buffer.
// ----------------------------------------------------------------------------
module base64_decoder
    import b64dec_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_char
    input  logic       s_axis_tlast,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic       m_axis_tlast
);

    // Input register.
    logic             r_stg_vld;
    logic [7:0]       r_char;
    logic             r_last;

    // Group state.
    logic [23:0]      r_grp_bits, n_grp_bits;
    logic [1:0]       r_grp_cnt,  n_grp_cnt;

    // Output buffer.
    t_entry           r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;

    logic             s_acc, m_pop;
    t_sextet          dec;
    logic [23:0]      bits_ins, bits_src;
    logic             close;
    logic [1:0]       push_n;
    logic [7:0]       push_byte [MAX_PUSH];
    logic [CNT_W:0]   room_sum;

    assign s_acc = s_axis_tvalid && s_axis_tready;
    assign m_pop = m_axis_tvalid && m_axis_tready;

    // Input register: takes an item whenever one is offered and there is room.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stg_vld <= 1'b0;
        end else begin
            r_stg_vld <= s_acc;
        end
        if (s_acc) begin
            r_char <= s_axis_tdata;
            r_last <= s_axis_tlast;
        end
    end

    // Decode the held character, update the group and pick the bytes to emit.
    always_comb begin
        dec        = sextet_of(r_char);
        close      = (r_char == PAD_CHAR) || r_last;
        n_grp_bits = r_grp_bits;
        n_grp_cnt  = r_grp_cnt;
        bits_src   = r_grp_bits;
        push_n     = 2'd0;
        case (r_grp_cnt)
            2'd0:    bits_ins = r_grp_bits | {dec.val, 18'd0};
            2'd1:    bits_ins = r_grp_bits | {6'd0, dec.val, 12'd0};
            2'd2:    bits_ins = r_grp_bits | {12'd0, dec.val, 6'd0};
            default: bits_ins = r_grp_bits | {18'd0, dec.val};
        endcase
        if (r_stg_vld) begin
            if (dec.vld) begin
                if (r_grp_cnt == 2'd3) begin
                    // Full group: three bytes leave, the group empties.
                    bits_src   = bits_ins;
                    push_n     = 2'd3;
                    n_grp_bits = 24'd0;
                    n_grp_cnt  = 2'd0;
                end else begin
                    n_grp_bits = bits_ins;
                    n_grp_cnt  = r_grp_cnt + 2'd1;
                end
            end
            // Pad or end of input flushes a partial group of two or three values; a lone value is dropped.
            if (close) begin
                if (n_grp_cnt >= 2'd2) begin
                    bits_src = n_grp_bits;
                    push_n   = n_grp_cnt - 2'd1;
                end
                n_grp_bits = 24'd0;
                n_grp_cnt  = 2'd0;
            end
        end
        push_byte[0] = bits_src[23:16];
        push_byte[1] = bits_src[15:8];
        push_byte[2] = bits_src[7:0];
    end

    // Group state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grp_bits <= 24'd0;
            r_grp_cnt  <= 2'd0;
        end else begin
            r_grp_bits <= n_grp_bits;
            r_grp_cnt  <= n_grp_cnt;
        end
    end

    // Output buffer: up to three writes and one read per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + PTR_W'(push_n);
            r_rd  <= r_rd + PTR_W'(m_pop);
            r_cnt <= r_cnt + CNT_W'(push_n) - CNT_W'(m_pop);
        end
        for (int k = 0; k < MAX_PUSH; k++) begin
            if (2'(k) < push_n) begin
                r_mem[r_wr + PTR_W'(k)].data <= push_byte[k];
                r_mem[r_wr + PTR_W'(k)].last <= (2'(k) == push_n - 2'd1);
            end
        end
    end

    // Room for the next item's bytes once the held item has written its own.
    assign room_sum      = (CNT_W + 1)'(r_cnt) + (CNT_W + 1)'(push_n);
    assign s_axis_tready = (room_sum <= (CNT_W + 1)'(READY_LIMIT));

    assign m_axis_tvalid = (r_cnt != '0);
    assign m_axis_tdata  = r_mem[r_rd].data;
    assign m_axis_tlast  = r_mem[r_rd].last;

    // The buffer never holds more than its depth.
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(FIFO_DEPTH))
        else $error("output buffer overflow");

    // A closing character always leaves an empty group behind.
    a_close_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stg_vld && close |=> r_grp_cnt == 2'd0 && r_grp_bits == 24'd0)
        else $error("group not cleared after pad or end of input");

    // Three bytes come only from a group that already held three values.
    a_full_group: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push_n == 2'd3 |-> r_grp_cnt == 2'd3 && dec.vld)
        else $error("three bytes from an incomplete group");

    // An accepted item never finds the buffer too full for its bytes.
    a_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |=> (CNT_W + 1)'(r_cnt) + (CNT_W + 1)'(push_n)
                  <= (CNT_W + 1)'(FIFO_DEPTH))
        else $error("accepted item without room for its bytes");

endmodule

>>> tb/base64_decoder_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base64 decoder checker
// Watches both stream channels of the decoder. It decodes every accepted
// character on its own, queues the bytes that should come out, and compares
// each byte that leaves the block with the oldest byte still expected.
// ----------------------------------------------------------------------------
module base64_decoder_check
    import b64dec_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    input  logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_char
    input  logic       s_axis_tlast,
    input  logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    input  logic [7:0] m_axis_tdata,   // [7:0] out_byte
    input  logic       m_axis_tlast,
    output int         o_fail_count,
    output int         o_pending
);

    localparam int REPORT_LIMIT = 10;

    string      alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    // Character lookup: whether a byte is in the alphabet, and its value.
    logic       sextet_ok  [256];
    logic [5:0] sextet_val [256];

    // Decoder state as the checker sees it.
    logic [23:0] grp_bits;
    logic [1:0]  grp_cnt;

    t_entry      expected_bytes [$];
    int          fail_cnt = 0;

    initial begin
        for (int i = 0; i < 256; i++) begin
            sextet_ok[i]  = 1'b0;
            sextet_val[i] = 6'd0;
        end
        for (int i = 0; i < 64; i++) begin
            sextet_ok[alphabet[i]]  = 1'b1;
            sextet_val[alphabet[i]] = 6'(i);
        end
    end

    // Decode one character and queue the bytes it releases, the final one
    // of them marked last.
    task automatic decode_char(input logic [7:0] ch, input logic eoi);
        logic [7:0] produced [3];
        int         n_out;
        int         n_tail;
        t_entry     e;
        n_out = 0;
        if (sextet_ok[ch]) begin
            grp_bits = grp_bits | (24'(sextet_val[ch]) << (6 * (3 - int'(grp_cnt))));
            if (grp_cnt == 2'd3) begin
                produced[0] = grp_bits[23:16];
                produced[1] = grp_bits[15:8];
                produced[2] = grp_bits[7:0];
                n_out       = 3;
                grp_bits    = '0;
                grp_cnt     = '0;
            end else begin
                grp_cnt = grp_cnt + 2'd1;
            end
        end
        // A pad or the end mark flushes a partial group; a lone value is lost.
        if (ch == PAD_CHAR || eoi) begin
            n_tail = int'(grp_cnt) - 1;
            for (int k = 0; k < n_tail; k++) begin
                produced[n_out] = grp_bits[23 - 8 * k -: 8];
                n_out++;
            end
            grp_bits = '0;
            grp_cnt  = '0;
        end
        for (int k = 0; k < n_out; k++) begin
            e.data = produced[k];
            e.last = (k == n_out - 1);
            expected_bytes = {expected_bytes, e};
        end
    endtask

    // Outputs are checked before the input of the same edge is decoded, so
    // a byte can never be matched against the character accepted with it.
    always @(posedge i_clk) begin
        t_entry want;
        if (!i_rst_n) begin
            grp_bits = '0;
            grp_cnt  = '0;
            expected_bytes.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_bytes.size() == 0) begin
                    if (fail_cnt < REPORT_LIMIT) begin
                        $display("unexpected byte %02h last %0b at %0t",
                                 m_axis_tdata, m_axis_tlast, $realtime);
                    end
                    fail_cnt++;
                end else begin
                    want = expected_bytes.pop_front();
                    if (m_axis_tdata !== want.data || m_axis_tlast !== want.last) begin
                        if (fail_cnt < REPORT_LIMIT) begin
                            $display({"byte mismatch at %0t: expected %02h last %0b,",
                                      " got %02h last %0b"},
                                     $realtime, want.data, want.last,
                                     m_axis_tdata, m_axis_tlast);
                        end
                        fail_cnt++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                decode_char(s_axis_tdata, s_axis_tlast);
            end
        end
        o_pending    = expected_bytes.size();
        o_fail_count = fail_cnt;
    end

endmodule

>>> tb/base64_decoder_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base64 decoder testbench
// Feeds the decoder a directed set of corner cases, then random Base64
// text mixed with stray bytes, under random sender gaps and receiver
// stalls. A separate checker predicts and compares every decoded byte.
// ----------------------------------------------------------------------------
module base64_decoder_test
    import b64dec_pkg::*;
();

    localparam int ITEM_TARGET = 220;
    localparam int IDLE_LIMIT  = 1000;
    localparam int TAIL_CYCLES = 8;

    // Receiver behavior modes.
    localparam int RX_FLOW = 0;
    localparam int RX_HOLD = 1;
    localparam int RX_COIN = 2;

    string      alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = 8'd0;   // [7:0] in_char
    logic       s_axis_tlast  = 1'b0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;           // [7:0] out_byte
    logic       m_axis_tlast;

    int         fail_count;
    int         pending;
    int         burst_left = 0;
    int         n_sent     = 0;
    int         rx_mode    = RX_FLOW;
    int         rx_left    = 0;
    int         idle_cycles = 0;

    always #10 i_clk = ~i_clk;

    base64_decoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    base64_decoder_check u_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    // Receiver: switches between free flow, hard stalls and coin-flip ready.
    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = $urandom_range(RX_FLOW, RX_COIN);
            rx_left = (rx_mode == RX_HOLD) ? $urandom_range(1, 12) : $urandom_range(4, 30);
        end
        rx_left--;
        case (rx_mode)
            RX_FLOW: m_axis_tready <= 1'b1;
            RX_HOLD: m_axis_tready <= 1'b0;
            default: m_axis_tready <= 1'($urandom_range(0, 1));
        endcase
    end

    // Watchdog: ends the run when no item moves on either side for too long.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL base64_decoder");
            $finish;
        end
    end

    // Offer one character at a falling edge and hold it until it is taken.
    // Characters go out in bursts separated by random gaps.
    task automatic push_char(input logic [7:0] ch, input logic eoi);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            repeat (gap) begin
                s_axis_tvalid <= 1'b0;
                @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ch;
        s_axis_tlast  <= eoi;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        @(negedge i_clk);
        burst_left--;
        n_sent++;
    endtask

    task automatic push_str(input string txt, input logic eoi_at_end);
        for (int i = 0; i < txt.len(); i++) begin
            push_char(txt[i], eoi_at_end && (i == txt.len() - 1));
        end
    endtask

    // One random frame: mostly Base64 text of random length, sometimes
    // padded, sometimes with stray bytes mixed in, and now and then raw noise.
    task automatic send_frame();
        int         shape;
        int         n_chars;
        int         n_pad;
        int         total;
        logic       eoi_at_end;
        logic [7:0] ch;
        shape      = $urandom_range(0, 9);
        eoi_at_end = ($urandom_range(0, 2) == 0);
        if (shape < 8) begin
            n_chars = $urandom_range(1, 10);
            n_pad   = ($urandom_range(0, 1) == 1 && (n_chars % 4) != 0)
                      ? 4 - n_chars % 4 : 0;
            total   = n_chars + n_pad;
            for (int k = 0; k < total; k++) begin
                if (shape == 7 && $urandom_range(0, 3) == 0) begin
                    push_char(8'($urandom_range(0, 255)), 1'b0);
                end
                ch = (k < n_chars) ? alphabet[$urandom_range(0, 63)] : PAD_CHAR;
                push_char(ch, eoi_at_end && (k == total - 1));
            end
        end else begin
            n_chars = $urandom_range(1, 6);
            for (int k = 0; k < n_chars; k++) begin
                push_char(8'($urandom_range(0, 255)), ($urandom_range(0, 4) == 0));
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Full group closed by the end mark on its fourth character.
        push_str("TWFu", 1'b1);
        // All-ones group with a stray byte inside that must not take a slot.
        push_str("//", 1'b0);
        push_char(8'hFF, 1'b0);
        push_str("//", 1'b0);
        // Start of the capital and digit ranges, end of the small-letter range, plus the + sign.
        push_str("Az0+", 1'b0);
        // Pad after three values with nonzero leftover bits.
        push_str("9Za", 1'b0);
        push_char(PAD_CHAR, 1'b0);
        // Pad on an empty group.
        push_char(PAD_CHAR, 1'b0);
        // A single value dropped by a pad, then a new group after the pad.
        push_str("Q", 1'b0);
        push_char(PAD_CHAR, 1'b0);
        // Ignored character that carries the end mark still closes the group.
        push_str("TW", 1'b0);
        push_char(8'h00, 1'b1);
        // End mark on two values.
        push_str("B+", 1'b1);

        while (n_sent < ITEM_TARGET) begin
            send_frame();
        end
        s_axis_tvalid <= 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("PASS base64_decoder");
        end else begin
            $display("FAIL base64_decoder");
        end
        $finish;
    end

endmodule
